// ===== rtl/core/dtg_pkg.sv =====
`default_nettype none

package dtg_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SAMPLE_W   = 32;
    localparam int LIM_W      = 31;
    localparam int GRAY_W     = 8;
    localparam int QUOT_W     = FRAC_BITS + 1;
    localparam int OPND_W     = 2 * FRAC_BITS + 2;
    localparam int SQ_REM_W   = FRAC_BITS + 3;
    localparam int DIV_CELLS  = FRAC_BITS;
    localparam int SQRT_CELLS = FRAC_BITS + 1;

    localparam logic [LIM_W-1:0]  LIMIT_RESET = LIM_W'(65536000);
    localparam logic [QUOT_W-1:0] ONE         = QUOT_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [LIM_W-1:0]  rem;
        logic [QUOT_W-1:0] quot;
    } t_div_data;

    typedef struct packed {
        logic [OPND_W-1:0]   opnd;
        logic [SQ_REM_W-1:0] rem;
        logic [QUOT_W-1:0]   root;
    } t_sqrt_data;

endpackage

`default_nettype wire

// ===== rtl/core/dtg_channels.sv =====
`default_nettype none

interface dtg_depth_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [dtg_pkg::SAMPLE_W-1:0]   depth_sample;
    modport source (output valid, output depth_sample, input ready);
    modport sink   (input valid, input depth_sample, output ready);
endinterface

interface dtg_gray_if;
    logic                           valid;
    logic                           ready;
    logic [dtg_pkg::GRAY_W-1:0]     gray_level;
    modport source (output valid, output gray_level, input ready);
    modport sink   (input valid, input gray_level, output ready);
endinterface

interface dtg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dtg_pkg::LIM_W-1:0]      depth_limit;
    modport source (output valid, output depth_limit, input ready);
    modport sink   (input valid, input depth_limit, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dtg_div_cell.sv =====
`default_nettype none

module dtg_div_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire dtg_pkg::t_div_data            i_data,
    input  wire logic [dtg_pkg::LIM_W-1:0]     i_limit,
    output logic                               o_valid,
    output dtg_pkg::t_div_data                 o_data
);

    logic [dtg_pkg::LIM_W:0] trial;
    logic [dtg_pkg::LIM_W:0] diff;
    logic                    ge;
    dtg_pkg::t_div_data      n_data;
    dtg_pkg::t_div_data      r_data;
    logic                    r_valid;

    always_comb begin
        trial       = {i_data.rem, 1'b0};
        diff        = trial - {1'b0, i_limit};
        ge          = trial >= {1'b0, i_limit};
        n_data.rem  = ge ? diff[dtg_pkg::LIM_W-1:0] : trial[dtg_pkg::LIM_W-1:0];
        n_data.quot = {i_data.quot[dtg_pkg::QUOT_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/dtg_sqrt_cell.sv =====
`default_nettype none

module dtg_sqrt_cell (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire dtg_pkg::t_sqrt_data     i_data,
    output logic                         o_valid,
    output dtg_pkg::t_sqrt_data          o_data
);

    logic [dtg_pkg::SQ_REM_W+1:0] cur;
    logic [dtg_pkg::SQ_REM_W+1:0] trial;
    logic [dtg_pkg::SQ_REM_W+1:0] diff;
    logic                         ge;
    dtg_pkg::t_sqrt_data          n_data;
    dtg_pkg::t_sqrt_data          r_data;
    logic                         r_valid;

    always_comb begin
        cur         = {i_data.rem, i_data.opnd[dtg_pkg::OPND_W-1 -: 2]};
        trial       = {2'b00, i_data.root, 2'b01};
        diff        = cur - trial;
        ge          = cur >= trial;
        n_data.rem  = ge ? diff[dtg_pkg::SQ_REM_W-1:0] : cur[dtg_pkg::SQ_REM_W-1:0];
        n_data.root = {i_data.root[dtg_pkg::QUOT_W-2:0], ge};
        n_data.opnd = {i_data.opnd[dtg_pkg::OPND_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/depth_to_gray_normalizer.sv =====
// Depth to gray normaliser.
// i_depth carries one signed Q16.16 depth sample per transaction; o_gray returns
// one 8-bit gray level per sample, in order (255 nearest, 0 at or beyond the limit).
// i_cfg writes depth_limit; it is always ready and must only be written while idle.
// Samples that are non-positive or above the limit are treated as the limit.
// Datapath: an input cell, 16 restoring-division cells (one quotient bit each),
// 17 square-root cells (one root bit each) and a gray scaling stage, all in a row.
// Throughput: one sample per cycle, sustained, while o_gray is ready.
// A one-entry skid register sits at the output: when the receiver stalls, the last
// result is parked there and the whole row of cells freezes until it is taken,
// so i_depth.ready drops the cycle after a stall starts and never depends on
// o_gray.ready combinationally.
// Reset (i_rst_n low, synchronous) empties every cell and the skid register and
// restores depth_limit to 1000.0.
`default_nettype none

module depth_to_gray_normalizer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dtg_depth_if.sink  i_depth,
    dtg_cfg_if.sink    i_cfg,
    dtg_gray_if.source o_gray
);

    logic [dtg_pkg::LIM_W-1:0] r_limit;
    logic                      en;

    logic [dtg_pkg::LIM_W-1:0] raw_mag;
    logic                      bad;
    logic [dtg_pkg::LIM_W-1:0] dval;
    logic                      full;
    dtg_pkg::t_div_data        n_in;

    logic                      w_div_v [dtg_pkg::DIV_CELLS+1];
    dtg_pkg::t_div_data        w_div   [dtg_pkg::DIV_CELLS+1];
    logic                      w_sq_v  [dtg_pkg::SQRT_CELLS+1];
    dtg_pkg::t_sqrt_data       w_sq    [dtg_pkg::SQRT_CELLS+1];

    logic [dtg_pkg::QUOT_W-1:0] ratio;
    logic [dtg_pkg::QUOT_W-1:0] inv;
    logic [dtg_pkg::QUOT_W+7:0] prod;

    logic                      r_in_valid;
    dtg_pkg::t_div_data        r_in;
    logic                      r_gray_valid;
    logic [dtg_pkg::GRAY_W-1:0] r_gray;
    logic                      r_skid_valid;
    logic [dtg_pkg::GRAY_W-1:0] r_skid;

    assign en            = !r_skid_valid;
    assign i_depth.ready = en;
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= dtg_pkg::LIMIT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_limit <= i_cfg.depth_limit;
        end
    end

    // input cell: substitute invalid samples; the full-scale flag enters at the
    // bottom of the quotient and reaches the top after the division cells
    always_comb begin
        raw_mag = i_depth.depth_sample[dtg_pkg::LIM_W-1:0];
        bad     = i_depth.depth_sample[dtg_pkg::SAMPLE_W-1] || (raw_mag == '0)
                  || (raw_mag > r_limit);
        dval    = bad ? r_limit : raw_mag;
        full    = (r_limit == '0) || (dval == r_limit);
        n_in.rem  = full ? '0 : dval;
        n_in.quot = {{dtg_pkg::FRAC_BITS{1'b0}}, full};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_depth.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= n_in;
        end
    end

    assign w_div_v[0] = r_in_valid;
    assign w_div[0]   = r_in;

    for (genvar g = 0; g < dtg_pkg::DIV_CELLS; g++) begin : g_div
        dtg_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_div_v[g]),
            .i_data  (w_div[g]),
            .i_limit (r_limit),
            .o_valid (w_div_v[g+1]),
            .o_data  (w_div[g+1])
        );
    end

    // top quotient bit set means full scale; clamp
    assign ratio = w_div[dtg_pkg::DIV_CELLS].quot[dtg_pkg::FRAC_BITS]
                   ? dtg_pkg::ONE
                   : {1'b0, w_div[dtg_pkg::DIV_CELLS].quot[dtg_pkg::FRAC_BITS-1:0]};

    assign w_sq_v[0]    = w_div_v[dtg_pkg::DIV_CELLS];
    assign w_sq[0].opnd = {1'b0, ratio, {dtg_pkg::FRAC_BITS{1'b0}}};
    assign w_sq[0].rem  = '0;
    assign w_sq[0].root = '0;

    for (genvar g = 0; g < dtg_pkg::SQRT_CELLS; g++) begin : g_sqrt
        dtg_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_sq_v[g]),
            .i_data  (w_sq[g]),
            .o_valid (w_sq_v[g+1]),
            .o_data  (w_sq[g+1])
        );
    end

    // 255 * (1 - s), keep the integer part
    always_comb begin
        inv  = dtg_pkg::ONE - w_sq[dtg_pkg::SQRT_CELLS].root;
        prod = {inv, 8'h00} - {8'h00, inv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_valid <= 1'b0;
        end else if (en) begin
            r_gray_valid <= w_sq_v[dtg_pkg::SQRT_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gray <= prod[dtg_pkg::FRAC_BITS+7:dtg_pkg::FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_gray.ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_gray_valid && !o_gray.ready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid <= r_gray;
        end
    end

    assign o_gray.valid      = r_skid_valid || r_gray_valid;
    assign o_gray.gray_level = r_skid_valid ? r_skid : r_gray;

    a_full_quot_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_v[dtg_pkg::DIV_CELLS] && w_div[dtg_pkg::DIV_CELLS].quot[dtg_pkg::FRAC_BITS])
        |-> ((w_div[dtg_pkg::DIV_CELLS].quot[dtg_pkg::FRAC_BITS-1:0] == '0)
             || (r_limit == '0)))
        else $error("full-scale quotient carries stray low bits");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_v[dtg_pkg::SQRT_CELLS] |-> (w_sq[dtg_pkg::SQRT_CELLS].root <= dtg_pkg::ONE))
        else $error("square root above full scale");

    a_freeze_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> ($stable(r_gray_valid) && $stable(r_in_valid)))
        else $error("pipeline moved while the skid register was occupied");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !o_gray.ready) |=> (r_skid_valid && $stable(r_skid)))
        else $error("parked result lost or changed during a stall");

endmodule

`default_nettype wire
